@@ rtl/grr_pkg.sv @@
package grr_pkg;

	// Glyph store geometry
	localparam int MAX_FONT_HEIGHT = 16;
	localparam int GLYPH_COUNT     = 256;
	localparam int ADDR_W          = $clog2(GLYPH_COUNT * MAX_FONT_HEIGHT);
	localparam int CNT_W           = $clog2(MAX_FONT_HEIGHT + 1);

	// Field widths
	localparam int CODE_W  = 8;
	localparam int GROW_W  = 4;
	localparam int POS_W   = 12;
	localparam int PITCH_W = 16;
	localparam int COLOR_W = 32;
	localparam int OFFS_W  = 32;
	localparam int NPIX    = 8;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_FONT_HEIGHT  = 3'd0,
		CFG_CHAR_ADVANCE = 3'd1,
		CFG_LINE_PITCH   = 3'd2,
		CFG_BPP          = 3'd3,
		CFG_BIG_ENDIAN   = 3'd4,
		CFG_FG_COLOR     = 3'd5,
		CFG_BG_COLOR     = 3'd6
	} grr_cfg_idx_t;

	// Item kinds carried in tuser
	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_DRAW = 1'b1
	} grr_mode_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // write one glyph row
		logic capture;  // latch draw item fields
		logic mul;      // form line start products
		logic start;    // set cursor and row offset, clear row count
		logic issue;    // read one glyph row into the output stage
		logic advance;  // move cursor by one character
	} grr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic rows_zero;   // font height is zero
		logic issue_last;  // the row about to be issued is the final one
		logic out_free;    // output stage can take a row this cycle
	} grr_stat_t;

endpackage

@@ rtl/grr_ram.sv @@
module grr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/grr_ctrl.sv @@
module grr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_mode,
	output logic                in_ready,
	input  grr_pkg::grr_stat_t  stat,
	output grr_pkg::grr_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_START,
		S_ROWS,
		S_ADV
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode commands from state
	always_comb begin
		cmd         = '0;
		cmd.load    = accept && (in_mode == grr_pkg::MODE_LOAD);
		cmd.capture = accept && (in_mode == grr_pkg::MODE_DRAW);
		cmd.mul     = (state_q == S_MUL);
		cmd.start   = (state_q == S_START);
		cmd.issue   = (state_q == S_ROWS) && stat.out_free;
		cmd.advance = (state_q == S_ADV);
	end

	// Sequence one draw transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= stat.rows_zero ? S_ADV : S_ROWS;
				end
				S_ROWS: begin
					if (stat.out_free && stat.issue_last) begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/grr_datapath.sv @@
module grr_datapath (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_we,
	input  logic [2:0]                                       cfg_index,
	input  logic [31:0]                                      cfg_wdata,
	input  logic [grr_pkg::CODE_W-1:0]                       char_code,
	input  logic [grr_pkg::GROW_W-1:0]                       glyph_row,
	input  logic [7:0]                                       row_bits,
	input  logic                                             first_char,
	input  logic [grr_pkg::POS_W-1:0]                        xpos,
	input  logic [grr_pkg::POS_W-1:0]                        ypos,
	input  grr_pkg::grr_cmd_t                                cmd,
	output grr_pkg::grr_stat_t                               stat,
	input  logic                                             out_ready,
	output logic                                             out_valid,
	output logic [grr_pkg::OFFS_W-1:0]                       row_offset,
	output logic [grr_pkg::NPIX-1:0][grr_pkg::COLOR_W-1:0]   pixels,
	output logic                                             last_row
);

	// Configuration registers
	logic [4:0]                        font_height_q;
	logic [6:0]                        char_advance_q;
	logic [grr_pkg::PITCH_W-1:0]       line_pitch_q;
	logic [2:0]                        bpp_cfg_q;
	logic                              big_endian_q;
	logic [grr_pkg::COLOR_W-1:0]       fg_color_q;
	logic [grr_pkg::COLOR_W-1:0]       bg_color_q;

	// Draw item and cursor
	logic [grr_pkg::CODE_W-1:0]        code_q;
	logic                              first_q;
	logic [grr_pkg::POS_W-1:0]         x_q;
	logic [grr_pkg::POS_W-1:0]         y_q;
	logic [grr_pkg::POS_W+grr_pkg::PITCH_W-1:0] ymul_s1;
	logic [grr_pkg::POS_W+2:0]         xmul_s1;
	logic [grr_pkg::OFFS_W-1:0]        cursor_q;
	logic [grr_pkg::OFFS_W-1:0]        line_off_q;
	logic [grr_pkg::CNT_W-1:0]         row_q;

	// Output stage
	logic                              valid_q;
	logic [grr_pkg::OFFS_W-1:0]        offset_q;
	logic                              last_q;
	logic                              code_ok_q;
	logic [7:0]                        glyph_bits;

	logic [2:0]                        bpp;
	logic [grr_pkg::CNT_W-1:0]         rows;
	logic [grr_pkg::OFFS_W-1:0]        cursor_start;
	logic [grr_pkg::COLOR_W-1:0]       fg_fmt;
	logic [grr_pkg::COLOR_W-1:0]       bg_fmt;
	logic                              load_ok;
	logic [grr_pkg::ADDR_W-1:0]        waddr;
	logic [grr_pkg::ADDR_W-1:0]        raddr;

	function automatic logic [grr_pkg::COLOR_W-1:0] fmt_pixel(
		input logic [grr_pkg::COLOR_W-1:0] c,
		input logic [2:0]                  size,
		input logic                        be
	);
		logic [grr_pkg::COLOR_W-1:0] r;
		unique case (size)
			3'd1:    r = {24'd0, c[7:0]};
			3'd2:    r = {16'd0, c[15:0]};
			3'd3:    r = be ? {8'd0, c[7:0], c[15:8], c[23:16]} : {8'd0, c[23:0]};
			default: r = c;
		endcase
		return r;
	endfunction

	// Clamp pixel size and row count
	always_comb begin
		if (bpp_cfg_q == 3'd0) begin
			bpp = 3'd1;
		end else if (bpp_cfg_q > 3'd4) begin
			bpp = 3'd4;
		end else begin
			bpp = bpp_cfg_q;
		end
		if (int'(font_height_q) > grr_pkg::MAX_FONT_HEIGHT) begin
			rows = grr_pkg::CNT_W'(grr_pkg::MAX_FONT_HEIGHT);
		end else begin
			rows = grr_pkg::CNT_W'(font_height_q);
		end
	end

	assign fg_fmt = fmt_pixel(fg_color_q, bpp, big_endian_q);
	assign bg_fmt = fmt_pixel(bg_color_q, bpp, big_endian_q);

	// Glyph store addressing
	assign load_ok = (int'(char_code) < grr_pkg::GLYPH_COUNT)
		&& (int'(glyph_row) < grr_pkg::MAX_FONT_HEIGHT);
	assign waddr = grr_pkg::ADDR_W'(int'(char_code) * grr_pkg::MAX_FONT_HEIGHT
		+ int'(glyph_row));
	assign raddr = grr_pkg::ADDR_W'(int'(code_q) * grr_pkg::MAX_FONT_HEIGHT + int'(row_q));

	grr_ram #(
		.WIDTH(8),
		.DEPTH(grr_pkg::GLYPH_COUNT * grr_pkg::MAX_FONT_HEIGHT)
	) u_glyph_ram (
		.clk   (clk),
		.we    (cmd.load && load_ok),
		.waddr (waddr),
		.wdata (row_bits),
		.re    (cmd.issue),
		.raddr (raddr),
		.rdata (glyph_bits)
	);

	// Status to controller
	assign stat.rows_zero  = (rows == '0);
	assign stat.issue_last = ((row_q + 1'b1) == rows);
	assign stat.out_free   = !valid_q || out_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_height_q  <= 5'd16;
			char_advance_q <= 7'd8;
			line_pitch_q   <= 16'd640;
			bpp_cfg_q      <= 3'd1;
			big_endian_q   <= 1'b0;
			fg_color_q     <= 32'h00FF_FFFF;
			bg_color_q     <= 32'h0000_0000;
		end else if (cfg_we) begin
			unique case (grr_pkg::grr_cfg_idx_t'(cfg_index))
				grr_pkg::CFG_FONT_HEIGHT:  font_height_q  <= cfg_wdata[4:0];
				grr_pkg::CFG_CHAR_ADVANCE: char_advance_q <= cfg_wdata[6:0];
				grr_pkg::CFG_LINE_PITCH:   line_pitch_q   <= cfg_wdata[15:0];
				grr_pkg::CFG_BPP:          bpp_cfg_q      <= cfg_wdata[2:0];
				grr_pkg::CFG_BIG_ENDIAN:   big_endian_q   <= cfg_wdata[0];
				grr_pkg::CFG_FG_COLOR:     fg_color_q     <= cfg_wdata;
				grr_pkg::CFG_BG_COLOR:     bg_color_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Latch draw fields and form line start products
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q  <= char_code;
			first_q <= first_char;
			x_q     <= xpos;
			y_q     <= ypos;
		end
		if (cmd.mul) begin
			ymul_s1 <= {{grr_pkg::PITCH_W{1'b0}}, y_q}
				* {{grr_pkg::POS_W{1'b0}}, line_pitch_q};
			xmul_s1 <= {3'd0, x_q} * {12'd0, bpp};
		end
	end

	assign cursor_start = first_q
		? (grr_pkg::OFFS_W'(ymul_s1) + grr_pkg::OFFS_W'(xmul_s1))
		: cursor_q;

	// Cursor, row count and row offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (cmd.start) begin
			cursor_q <= cursor_start;
		end else if (cmd.advance) begin
			cursor_q <= cursor_q + ({25'd0, char_advance_q} * {29'd0, bpp});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			line_off_q <= cursor_start;
			row_q      <= '0;
		end else if (cmd.issue) begin
			line_off_q <= line_off_q + grr_pkg::OFFS_W'(line_pitch_q);
			row_q      <= row_q + 1'b1;
		end
	end

	// Output stage: load on issue, drop valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.issue) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			offset_q  <= line_off_q;
			last_q    <= stat.issue_last;
			code_ok_q <= (int'(code_q) < grr_pkg::GLYPH_COUNT);
		end
	end

	// Expand glyph bits to pixels, leftmost from bit 7
	always_comb begin
		for (int k = 0; k < grr_pkg::NPIX; k++) begin
			pixels[k] = (code_ok_q && glyph_bits[grr_pkg::NPIX-1-k]) ? fg_fmt : bg_fmt;
		end
	end

	assign out_valid  = valid_q;
	assign row_offset = offset_q;
	assign last_row   = last_q;

	a_issue_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (!valid_q || out_ready))
		else $error("row issued over a held output");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && stat.issue_last) |=> (valid_q && last_q))
		else $error("final row not marked");

	a_start_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> $past(cmd.mul))
		else $error("cursor set without products");

endmodule

@@ rtl/glyph_row_rasterizer_unit.sv @@
// Text-mode character generator. A load transaction (tuser = 0) writes one
// 8-bit glyph row into a 256-code by 16-row font RAM. A draw transaction
// (tuser = 1) renders one character: it produces one output transaction per
// glyph row, font_height rows in all (at most 16), each with the byte offset
// of the row in the frame and eight pixels in fg or bg color, tlast on the
// final row. A draw occupies the input while it is accepted, while the line
// start products ypos * line_pitch and xpos * bytes_per_pixel are formed,
// while the cursor is set, while each of its rows, font_height capped at 16,
// is read through the single read port of the font RAM (a row waits while
// the output is held), and while the cursor is advanced. The next
// transaction is accepted while the final row still waits at the output.
// Font rows that were never loaded read as undefined data.
module glyph_row_rasterizer_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// char_code[7:0], glyph_row[11:8], row_bits[19:12], first_char[20],
	// xpos[32:21], ypos[44:33], zero fill[47:45]
	input  logic [47:0]  s_axis_tdata,
	// mode[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// row_offset[31:0], pixel_0[63:32], pixel_1[95:64] ... pixel_7[287:256]
	output logic [287:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	grr_pkg::grr_cmd_t                               cmd;
	grr_pkg::grr_stat_t                              stat;
	logic [grr_pkg::OFFS_W-1:0]                      row_offset;
	logic [grr_pkg::NPIX-1:0][grr_pkg::COLOR_W-1:0]  pixels;

	grr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	grr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.char_code  (s_axis_tdata[7:0]),
		.glyph_row  (s_axis_tdata[11:8]),
		.row_bits   (s_axis_tdata[19:12]),
		.first_char (s_axis_tdata[20]),
		.xpos       (s_axis_tdata[32:21]),
		.ypos       (s_axis_tdata[44:33]),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.row_offset (row_offset),
		.pixels     (pixels),
		.last_row   (m_axis_tlast)
	);

	// Pack the result transaction
	assign m_axis_tdata = {pixels, row_offset};

endmodule
